### rtl/cst_pkg.sv
// Shared types, codes and character-class helpers for the C subset tokenizer.
// No dependencies; imported by cst_lexer, c_subset_tokenizer_core and cst_checker.
package cst_pkg;

    localparam int LINE_BITS_DEF   = 20;
    localparam int LENGTH_BITS_DEF = 16;

    // Up to three records come from one source byte.
    localparam int REC_SLOTS = 3;

    // Record queue between lexer and output port, in rows of one byte's records.
    localparam int ROW_DEPTH    = 4;
    localparam int ROW_PTR_BITS = $clog2(ROW_DEPTH);
    localparam int ROW_CNT_BITS = $clog2(ROW_DEPTH + 1);

    localparam logic [1:0] REC_TOKEN   = 2'd0;
    localparam logic [1:0] REC_LITERAL = 2'd1;
    localparam logic [1:0] REC_ERROR   = 2'd2;

    localparam logic [4:0] KIND_END     = 5'd0;
    localparam logic [4:0] KIND_NL      = 5'd1;
    localparam logic [4:0] KIND_SPACE   = 5'd2;
    localparam logic [4:0] KIND_NUM     = 5'd3;
    localparam logic [4:0] KIND_CHAR    = 5'd4;
    localparam logic [4:0] KIND_STR     = 5'd5;
    localparam logic [4:0] KIND_IDENT   = 5'd6;
    localparam logic [4:0] KIND_LE      = 5'd7;
    localparam logic [4:0] KIND_GE      = 5'd8;
    localparam logic [4:0] KIND_EQ      = 5'd9;
    localparam logic [4:0] KIND_NE      = 5'd10;
    localparam logic [4:0] KIND_INC     = 5'd11;
    localparam logic [4:0] KIND_DEC     = 5'd12;
    localparam logic [4:0] KIND_LAND    = 5'd13;
    localparam logic [4:0] KIND_LOR     = 5'd14;
    localparam logic [4:0] KIND_ARROW   = 5'd15;
    localparam logic [4:0] KIND_VARARGS = 5'd16;
    localparam logic [4:0] KIND_SINGLE  = 5'd17;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_EOF_LIT    = 3'd1;
    localparam logic [2:0] ERR_NL_LIT     = 3'd2;
    localparam logic [2:0] ERR_BAD_ESC    = 3'd3;
    localparam logic [2:0] ERR_OPEN_CMT   = 3'd4;
    localparam logic [2:0] ERR_OPEN_CHAR  = 3'd5;
    localparam logic [2:0] ERR_DOUBLE_DOT = 3'd6;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_BAR    = 8'h7C;

    // Fixed-width part of one record; line and length follow module parameters.
    typedef struct packed {
        logic [1:0] rtype;
        logic [4:0] kind;
        logic [7:0] single_ch;
        logic [7:0] lit;
        logic [2:0] err;
        logic       last;
    } t_rec_meta;

    function automatic t_rec_meta mk_meta(logic [1:0] rtype, logic [4:0] kind,
                                          logic [7:0] single_ch, logic [7:0] lit,
                                          logic [2:0] err);
        t_rec_meta m;
        m.rtype     = rtype;
        m.kind      = kind;
        m.single_ch = single_ch;
        m.lit       = lit;
        m.err       = err;
        m.last      = 1'b0;
        return m;
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_word(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_USCORE;
    endfunction

    function automatic logic is_op_start(logic [7:0] c);
        return c == CH_LT || c == CH_GT || c == CH_EQ || c == CH_BANG ||
               c == CH_PLUS || c == CH_MINUS || c == CH_AMP || c == CH_BAR;
    endfunction

    function automatic logic esc_ok(logic [7:0] c);
        return c == CH_ZERO || c == CH_SQUOTE || c == CH_DQUOTE ||
               c == CH_LC_N || c == CH_BSLASH;
    endfunction

    function automatic logic [7:0] esc_val(logic [7:0] c);
        logic [7:0] v;
        v = c;
        if (c == CH_ZERO) v = CH_NUL;
        else if (c == CH_LC_N) v = CH_NL;
        return v;
    endfunction

    // Two-character operator kind, KIND_END when the pair forms none.
    function automatic logic [4:0] pair_kind(logic [7:0] a, logic [7:0] b);
        logic [4:0] k;
        k = KIND_END;
        if (a == CH_LT && b == CH_EQ) k = KIND_LE;
        else if (a == CH_GT && b == CH_EQ) k = KIND_GE;
        else if (a == CH_EQ && b == CH_EQ) k = KIND_EQ;
        else if (a == CH_BANG && b == CH_EQ) k = KIND_NE;
        else if (a == CH_PLUS && b == CH_PLUS) k = KIND_INC;
        else if (a == CH_MINUS && b == CH_MINUS) k = KIND_DEC;
        else if (a == CH_AMP && b == CH_AMP) k = KIND_LAND;
        else if (a == CH_BAR && b == CH_BAR) k = KIND_LOR;
        else if (a == CH_MINUS && b == CH_GT) k = KIND_ARROW;
        return k;
    endfunction

endpackage

### rtl/cst_lexer.sv
// Lexer mode machine: holds mode, lookahead, line and length counters.
// Produces up to three compacted records per accepted byte. Uses cst_pkg.
module cst_lexer
    import cst_pkg::*;
#(
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [7:0]             i_char,
    output logic [1:0]             o_rec_cnt,
    output t_rec_meta              o_meta [REC_SLOTS],
    output logic [LINE_BITS-1:0]   o_line [REC_SLOTS],
    output logic [LENGTH_BITS-1:0] o_len  [REC_SLOTS]
);

    typedef enum logic [3:0] {
        M_IDLE, M_WS, M_NUM, M_IDENT, M_SLASH, M_COMMENT, M_CSTAR,
        M_CHR, M_CHR_ESC, M_CHR_CLOSE, M_STR, M_STR_ESC, M_OP1, M_DOT1, M_DOT2
    } t_mode;

    localparam logic [LINE_BITS-1:0]   LINE_ONE  = LINE_BITS'(1);
    localparam logic [LINE_BITS-1:0]   LINE_MAX  = {LINE_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] LEN_ZERO  = '0;
    localparam logic [LENGTH_BITS-1:0] LEN_ONE   = LENGTH_BITS'(1);
    localparam logic [LENGTH_BITS-1:0] LEN_TWO   = LENGTH_BITS'(2);
    localparam logic [LENGTH_BITS-1:0] LEN_THREE = LENGTH_BITS'(3);
    localparam logic [LENGTH_BITS-1:0] LEN_MAX   = {LENGTH_BITS{1'b1}};

    t_mode                  r_mode,   n_mode;
    logic [7:0]             r_la,     n_la;
    logic [LINE_BITS-1:0]   r_line,   n_line;
    logic [LINE_BITS-1:0]   r_sline,  n_sline;
    logic [LENGTH_BITS-1:0] r_len,    n_len;
    logic                   r_halted, n_halted;

    logic [LINE_BITS-1:0]   line_p1;
    logic [LENGTH_BITS-1:0] len_p1;
    logic                   start;
    logic                   is_chr;
    logic [4:0]             lit_kind;
    logic [4:0]             pk;

    // Slot 0: lone ".." error; slot 1: record of the open token; slot 2: new token.
    logic [REC_SLOTS-1:0]   slot_v;
    logic [REC_SLOTS-1:0]   slot_last;
    t_rec_meta              slot_m    [REC_SLOTS];
    logic [LINE_BITS-1:0]   slot_line [REC_SLOTS];
    logic [LENGTH_BITS-1:0] slot_len  [REC_SLOTS];

    assign line_p1 = (r_line == LINE_MAX) ? r_line : r_line + LINE_ONE;
    assign len_p1  = (r_len == LEN_MAX) ? r_len : r_len + LEN_ONE;
    assign is_chr  = (r_mode == M_CHR) || (r_mode == M_CHR_ESC);
    assign lit_kind = is_chr ? KIND_CHAR : KIND_STR;
    assign pk      = pair_kind(r_la, i_char);

    always_comb begin
        n_mode   = r_mode;
        n_la     = r_la;
        n_line   = r_line;
        n_sline  = r_sline;
        n_len    = r_len;
        n_halted = r_halted;
        start    = 1'b0;
        slot_v   = '0;
        for (int s = 0; s < REC_SLOTS; s++) begin
            slot_m[s]    = mk_meta(REC_TOKEN, KIND_END, CH_NUL, CH_NUL, ERR_NONE);
            slot_len[s]  = LEN_ZERO;
            slot_line[s] = r_sline;
        end
        slot_line[2] = r_line;

        if (!r_halted) begin
            unique case (r_mode) inside
                M_WS: begin
                    if (is_space(i_char) && i_char != CH_NL) begin
                        n_len = len_p1;
                    end else begin
                        slot_v[1]   = 1'b1;
                        slot_m[1]   = mk_meta(REC_TOKEN, KIND_SPACE, CH_NUL, CH_NUL, ERR_NONE);
                        slot_len[1] = r_len;
                        start       = 1'b1;
                    end
                end
                M_NUM: begin
                    if (is_digit(i_char)) begin
                        n_len = len_p1;
                    end else begin
                        slot_v[1]   = 1'b1;
                        slot_m[1]   = mk_meta(REC_TOKEN, KIND_NUM, CH_NUL, CH_NUL, ERR_NONE);
                        slot_len[1] = r_len;
                        start       = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_word(i_char)) begin
                        n_len = len_p1;
                    end else begin
                        slot_v[1]   = 1'b1;
                        slot_m[1]   = mk_meta(REC_TOKEN, KIND_IDENT, CH_NUL, CH_NUL, ERR_NONE);
                        slot_len[1] = r_len;
                        start       = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (i_char == CH_STAR) begin
                        n_len  = len_p1;
                        n_mode = M_COMMENT;
                    end else begin
                        slot_v[1]   = 1'b1;
                        slot_m[1]   = mk_meta(REC_TOKEN, KIND_SINGLE, CH_SLASH, CH_NUL,
                                              ERR_NONE);
                        slot_len[1] = LEN_ONE;
                        start       = 1'b1;
                    end
                end
                M_COMMENT, M_CSTAR: begin
                    if (i_char == CH_SLASH && r_mode == M_CSTAR) begin
                        slot_v[1]   = 1'b1;
                        slot_m[1]   = mk_meta(REC_TOKEN, KIND_SPACE, CH_NUL, CH_NUL, ERR_NONE);
                        slot_len[1] = LEN_ONE;
                        n_mode      = M_IDLE;
                    end else if (i_char == CH_NUL) begin
                        slot_v[1] = 1'b1;
                        slot_m[1] = mk_meta(REC_ERROR, KIND_END, CH_NUL, CH_NUL, ERR_OPEN_CMT);
                        n_mode    = M_IDLE;
                        n_halted  = 1'b1;
                    end else begin
                        n_len = len_p1;
                        if (i_char == CH_NL) n_line = line_p1;
                        n_mode = (i_char == CH_STAR) ? M_CSTAR : M_COMMENT;
                    end
                end
                M_CHR, M_STR: begin
                    if (!is_chr && i_char == CH_DQUOTE) begin
                        n_len       = len_p1;
                        slot_v[1]   = 1'b1;
                        slot_m[1]   = mk_meta(REC_TOKEN, KIND_STR, CH_NUL, CH_NUL, ERR_NONE);
                        slot_len[1] = len_p1;
                        n_mode      = M_IDLE;
                    end else if (i_char == CH_NUL || i_char == CH_NL) begin
                        slot_v[1]    = 1'b1;
                        slot_m[1]    = mk_meta(REC_ERROR, KIND_END, CH_NUL, CH_NUL,
                                               (i_char == CH_NUL) ? ERR_EOF_LIT : ERR_NL_LIT);
                        slot_line[1] = r_line;
                        n_mode       = M_IDLE;
                        n_halted     = 1'b1;
                    end else if (i_char == CH_BSLASH) begin
                        n_len  = len_p1;
                        n_mode = is_chr ? M_CHR_ESC : M_STR_ESC;
                    end else begin
                        n_len     = len_p1;
                        slot_v[1] = 1'b1;
                        slot_m[1] = mk_meta(REC_LITERAL, lit_kind, CH_NUL, i_char, ERR_NONE);
                        n_mode    = is_chr ? M_CHR_CLOSE : M_STR;
                    end
                end
                M_CHR_ESC, M_STR_ESC: begin
                    slot_v[1] = 1'b1;
                    if (esc_ok(i_char)) begin
                        n_len     = len_p1;
                        slot_m[1] = mk_meta(REC_LITERAL, lit_kind, CH_NUL, esc_val(i_char),
                                            ERR_NONE);
                        n_mode    = is_chr ? M_CHR_CLOSE : M_STR;
                    end else begin
                        slot_m[1]    = mk_meta(REC_ERROR, KIND_END, CH_NUL, CH_NUL,
                                               ERR_BAD_ESC);
                        slot_line[1] = r_line;
                        n_mode       = M_IDLE;
                        n_halted     = 1'b1;
                    end
                end
                M_CHR_CLOSE: begin
                    slot_v[1] = 1'b1;
                    n_mode    = M_IDLE;
                    if (i_char == CH_SQUOTE) begin
                        n_len       = len_p1;
                        slot_m[1]   = mk_meta(REC_TOKEN, KIND_CHAR, CH_NUL, CH_NUL, ERR_NONE);
                        slot_len[1] = len_p1;
                    end else begin
                        slot_m[1] = mk_meta(REC_ERROR, KIND_END, CH_NUL, CH_NUL,
                                            ERR_OPEN_CHAR);
                        n_halted  = 1'b1;
                    end
                end
                M_OP1: begin
                    slot_v[1] = 1'b1;
                    if (pk != KIND_END) begin
                        slot_m[1]   = mk_meta(REC_TOKEN, pk, CH_NUL, CH_NUL, ERR_NONE);
                        slot_len[1] = LEN_TWO;
                        n_mode      = M_IDLE;
                    end else begin
                        slot_m[1]   = mk_meta(REC_TOKEN, KIND_SINGLE, r_la, CH_NUL, ERR_NONE);
                        slot_len[1] = LEN_ONE;
                        start       = 1'b1;
                    end
                end
                M_DOT1: begin
                    if (i_char == CH_DOT) begin
                        n_len  = len_p1;
                        n_mode = M_DOT2;
                    end else begin
                        slot_v[1]   = 1'b1;
                        slot_m[1]   = mk_meta(REC_TOKEN, KIND_SINGLE, CH_DOT, CH_NUL, ERR_NONE);
                        slot_len[1] = LEN_ONE;
                        start       = 1'b1;
                    end
                end
                M_DOT2: begin
                    slot_v[1] = 1'b1;
                    if (i_char == CH_DOT) begin
                        slot_m[1]   = mk_meta(REC_TOKEN, KIND_VARARGS, CH_NUL, CH_NUL,
                                              ERR_NONE);
                        slot_len[1] = LEN_THREE;
                        n_mode      = M_IDLE;
                    end else begin
                        slot_v[0]   = 1'b1;
                        slot_m[0]   = mk_meta(REC_ERROR, KIND_END, CH_NUL, CH_NUL,
                                              ERR_DOUBLE_DOT);
                        slot_m[1]   = mk_meta(REC_TOKEN, KIND_SINGLE, CH_DOT, CH_NUL, ERR_NONE);
                        slot_len[1] = LEN_TWO;
                        start       = 1'b1;
                    end
                end
                default: begin
                    start = 1'b1;
                end
            endcase

            // The byte opens a new token; a few classes complete at once.
            if (start) begin
                n_sline = r_line;
                n_len   = LEN_ONE;
                n_mode  = M_IDLE;
                if (i_char == CH_NUL) begin
                    slot_v[2] = 1'b1;
                    slot_m[2] = mk_meta(REC_TOKEN, KIND_END, CH_NUL, CH_NUL, ERR_NONE);
                    n_la      = CH_NUL;
                    n_line    = LINE_ONE;
                    n_sline   = LINE_ONE;
                    n_len     = LEN_ZERO;
                    n_halted  = 1'b0;
                end else if (i_char == CH_NL) begin
                    slot_v[2]   = 1'b1;
                    slot_m[2]   = mk_meta(REC_TOKEN, KIND_NL, CH_NUL, CH_NUL, ERR_NONE);
                    slot_len[2] = LEN_ONE;
                    n_line      = line_p1;
                end else if (is_space(i_char)) begin
                    n_mode = M_WS;
                end else if (i_char == CH_SLASH) begin
                    n_mode = M_SLASH;
                end else if (is_digit(i_char)) begin
                    n_mode = M_NUM;
                end else if (is_alpha(i_char) || i_char == CH_USCORE) begin
                    n_mode = M_IDENT;
                end else if (i_char == CH_SQUOTE) begin
                    n_mode = M_CHR;
                end else if (i_char == CH_DQUOTE) begin
                    n_mode = M_STR;
                end else if (is_op_start(i_char)) begin
                    n_mode = M_OP1;
                    n_la   = i_char;
                end else if (i_char == CH_DOT) begin
                    n_mode = M_DOT1;
                end else begin
                    slot_v[2]   = 1'b1;
                    slot_m[2]   = mk_meta(REC_TOKEN, KIND_SINGLE, i_char, CH_NUL, ERR_NONE);
                    slot_len[2] = LEN_ONE;
                end
            end
        end
    end

    // A slot is final when no later slot is present.
    assign slot_last[0] = !slot_v[1] && !slot_v[2];
    assign slot_last[1] = !slot_v[2];
    assign slot_last[2] = 1'b1;

    // Pack present slots to the front, in order, and mark the final one.
    always_comb begin
        o_rec_cnt = 2'd0;
        for (int s = 0; s < REC_SLOTS; s++) begin
            o_meta[s] = mk_meta(REC_TOKEN, KIND_END, CH_NUL, CH_NUL, ERR_NONE);
            o_line[s] = r_line;
            o_len[s]  = LEN_ZERO;
        end
        for (int s = 0; s < REC_SLOTS; s++) begin
            if (slot_v[s]) begin
                o_meta[o_rec_cnt]      = slot_m[s];
                o_meta[o_rec_cnt].last = slot_last[s];
                o_line[o_rec_cnt]      = slot_line[s];
                o_len[o_rec_cnt]       = slot_len[s];
                o_rec_cnt              = o_rec_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_la     <= CH_NUL;
            r_line   <= LINE_ONE;
            r_sline  <= LINE_ONE;
            r_len    <= LEN_ZERO;
            r_halted <= 1'b0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_la     <= n_la;
            r_line   <= n_line;
            r_sline  <= n_sline;
            r_len    <= n_len;
            r_halted <= n_halted;
        end
    end

endmodule

### rtl/c_subset_tokenizer_core.sv
// Top level of the C subset tokenizer: byte input, lexer and record queue.
// Depends on cst_pkg and cst_lexer.
//
// Streaming tokenizer for a small C subset. Each accepted byte on the input
// channel steps the lexer mode machine in the same cycle and yields zero to
// three records: completed tokens, decoded bytes of character and string
// literals, or an error. A token completes only when the byte after it
// arrives, so the records a byte produces may belong to the previous token.
// A NUL byte outside a comment or a character or string literal closes
// any open token, emits the end token and restarts line counting at one.
// After any error other than a lone "..", the block accepts and drops every
// byte until reset. Records of one byte enter a four-row queue as one row
// and leave one per beat, the final record of each byte marked by o_last.
// A byte is accepted every cycle while the queue has a free row, so the
// input runs at one byte per cycle when every byte yields at most one
// record and the sink is ready; when bytes yield two or three records, the
// output sustains one record per cycle while the sink is ready. Line and
// length counters saturate at their all-ones value.
module c_subset_tokenizer_core
    import cst_pkg::*;
#(
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Source byte channel
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [7:0]             i_char_in,
    // Record channel
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [1:0]             o_record_type,
    output logic [4:0]             o_token_kind,
    output logic [7:0]             o_single_char,
    output logic [LINE_BITS-1:0]   o_token_line,
    output logic [LENGTH_BITS-1:0] o_token_length,
    output logic [7:0]             o_literal_byte,
    output logic [2:0]             o_error_code,
    output logic                   o_last
);

    localparam logic [ROW_CNT_BITS-1:0] ROW_FULL = ROW_CNT_BITS'(ROW_DEPTH);

    logic                   in_accept;
    logic                   out_fire;
    logic                   push;
    logic                   pop;

    logic [1:0]             lx_cnt;
    t_rec_meta              lx_meta [REC_SLOTS];
    logic [LINE_BITS-1:0]   lx_line [REC_SLOTS];
    logic [LENGTH_BITS-1:0] lx_len  [REC_SLOTS];

    // Queue rows: all records of one byte.
    t_rec_meta              r_row_meta [ROW_DEPTH][REC_SLOTS];
    logic [LINE_BITS-1:0]   r_row_line [ROW_DEPTH][REC_SLOTS];
    logic [LENGTH_BITS-1:0] r_row_len  [ROW_DEPTH][REC_SLOTS];

    logic [ROW_PTR_BITS-1:0] r_wr_ptr;
    logic [ROW_PTR_BITS-1:0] r_rd_ptr;
    logic [ROW_CNT_BITS-1:0] r_count;
    logic [1:0]              r_sub;     // record within the head row

    t_rec_meta              head;

    // Input side never waits on the output handshake: only a full queue holds it.
    assign o_in_ready  = (r_count != ROW_FULL);
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = (r_count != '0);
    assign out_fire    = o_out_valid && i_out_ready;

    // A byte with no records leaves no row behind.
    assign push = in_accept && (lx_cnt != 2'd0);
    // Retire the head row after its last record goes out.
    assign pop  = out_fire && head.last;

    cst_lexer #(
        .LINE_BITS   (LINE_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_lexer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_char    (i_char_in),
        .o_rec_cnt (lx_cnt),
        .o_meta    (lx_meta),
        .o_line    (lx_line),
        .o_len     (lx_len)
    );

    // Row storage: payload only, no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            for (int s = 0; s < REC_SLOTS; s++) begin
                r_row_meta[r_wr_ptr][s] <= lx_meta[s];
                r_row_line[r_wr_ptr][s] <= lx_line[s];
                r_row_len[r_wr_ptr][s]  <= lx_len[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_sub    <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
                r_sub    <= 2'd0;
            end else if (out_fire) begin
                r_sub <= r_sub + 2'd1;
            end
            if (push && !pop) r_count <= r_count + 1'b1;
            else if (pop && !push) r_count <= r_count - 1'b1;
        end
    end

    assign head           = r_row_meta[r_rd_ptr][r_sub];
    assign o_record_type  = head.rtype;
    assign o_token_kind   = head.kind;
    assign o_single_char  = head.single_ch;
    assign o_literal_byte = head.lit;
    assign o_error_code   = head.err;
    assign o_last         = head.last;
    assign o_token_line   = r_row_line[r_rd_ptr][r_sub];
    assign o_token_length = r_row_len[r_rd_ptr][r_sub];

endmodule

### rtl/cst_checker.sv
// Port-level checks on the tokenizer's record channel, bound to the top level.
// Depends on cst_pkg and c_subset_tokenizer_core.
module cst_checker
    import cst_pkg::*;
#(
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [1:0]             i_record_type,
    input logic [4:0]             i_token_kind,
    input logic [LINE_BITS-1:0]   i_token_line,
    input logic [LENGTH_BITS-1:0] i_token_length,
    input logic [2:0]             i_error_code,
    input logic                   i_last
);

    // Hold a stalled beat.
    ap_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_record_type) &&
        $stable(i_token_kind) && $stable(i_token_line) && $stable(i_token_length) &&
        $stable(i_error_code) && $stable(i_last))
        else $error("record beat changed while stalled");

    // Error records carry a code, kind end and no length; others carry no code.
    ap_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_record_type == REC_ERROR) ==
                         (i_error_code != ERR_NONE)) &&
        (i_record_type != REC_ERROR ||
         (i_token_kind == KIND_END && i_token_length == '0)))
        else $error("malformed error record");

    // Literal bytes belong to a char or string token and span no length.
    ap_lit_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_record_type == REC_LITERAL |->
        (i_token_kind == KIND_CHAR || i_token_kind == KIND_STR) &&
        i_token_length == '0)
        else $error("malformed literal record");

    // The end token is always the final record of its byte, with zero length.
    ap_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_record_type == REC_TOKEN && i_token_kind == KIND_END |->
        i_last && i_token_length == '0)
        else $error("end token not last or has length");

endmodule

bind c_subset_tokenizer_core cst_checker #(
    .LINE_BITS   (LINE_BITS),
    .LENGTH_BITS (LENGTH_BITS)
) u_cst_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .i_record_type  (o_record_type),
    .i_token_kind   (o_token_kind),
    .i_token_line   (o_token_line),
    .i_token_length (o_token_length),
    .i_error_code   (o_error_code),
    .i_last         (o_last)
);

### sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for c_subset_tokenizer_core: streams source bytes, predicts each beat.
// Depends on cst_pkg (codes, character constants) and the c_subset_tokenizer_core RTL.
module testbench;
    import cst_pkg::*;

    localparam int LINE_W       = LINE_BITS_DEF;
    localparam int LEN_W        = LENGTH_BITS_DEF;
    localparam int HOLD_CYCLES  = 80;
    localparam int RANDOM_BYTES = 170;
    localparam int DRAIN_LIMIT  = 5000;

    // One record beat, as seen on the output channel.
    typedef struct packed {
        logic [1:0]        rtype;
        logic [4:0]        kind;
        logic [7:0]        schar;
        logic [LINE_W-1:0] tline;
        logic [LEN_W-1:0]  tlen;
        logic [7:0]        lit;
        logic [2:0]        err;
        logic              last;
    } t_tok_rec;

    // Directed row: a typed row carries its single token record, on line 1.
    typedef struct {
        logic [7:0]       ch;
        bit               typed;
        logic [4:0]       kind;
        logic [7:0]       schar;
        logic [LEN_W-1:0] tlen;
    } t_script_row;

    typedef enum logic [3:0] {
        LX_IDLE, LX_WS, LX_NUM, LX_IDENT, LX_SLASH, LX_COMMENT, LX_CSTAR,
        LX_CHR, LX_CHR_ESC, LX_CHR_CLOSE, LX_STR, LX_STR_ESC, LX_OP1,
        LX_DOT1, LX_DOT2
    } t_lex_mode;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic [7:0]        i_char_in = 8'h00;
    logic              i_out_ready = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [1:0]        o_record_type;
    logic [4:0]        o_token_kind;
    logic [7:0]        o_single_char;
    logic [LINE_W-1:0] o_token_line;
    logic [LEN_W-1:0]  o_token_length;
    logic [7:0]        o_literal_byte;
    logic [2:0]        o_error_code;
    logic              o_last;

    // Lexer shadow state, advanced on every accepted byte.
    t_lex_mode         lx_mode;
    logic [7:0]        lx_pending_op;
    logic [LINE_W-1:0] lx_line;
    logic [LINE_W-1:0] lx_tok_line;
    logic [LEN_W-1:0]  lx_len;
    bit                lx_halted;

    t_tok_rec   step_recs[$];   // records caused by the byte just accepted
    t_tok_rec   awaited[$];     // records still owed by the block, oldest first
    logic [7:0] tok_bytes[$];   // bytes of the random token being sent

    int       fail_count = 0;
    bit       calm = 1'b0;      // no gaps and no new sink stalls while set
    bit       hold_req = 1'b0;  // ask the sink for one long hold-off
    bit       typed_beat = 1'b0;
    t_tok_rec typed_want;

    // Directed table: extremes of the byte, every record type, a lone "..", end of input.
    t_script_row script[21] = '{
        '{CH_NUL,    1'b1, KIND_END,    8'h00,  16'd0},  // end of input right after reset
        '{8'hFF,     1'b1, KIND_SINGLE, 8'hFF,  16'd1},  // top byte: single token
        '{8'h80,     1'b1, KIND_SINGLE, 8'h80,  16'd1},
        '{CH_NL,     1'b1, KIND_NL,     8'h00,  16'd1},
        '{CH_USCORE, 1'b0, KIND_END,    8'h00,  16'd0},
        '{"z",       1'b0, KIND_END,    8'h00,  16'd0},
        '{"9",       1'b0, KIND_END,    8'h00,  16'd0},
        '{8'h09,     1'b0, KIND_END,    8'h00,  16'd0},
        '{CH_LT,     1'b0, KIND_END,    8'h00,  16'd0},
        '{CH_EQ,     1'b0, KIND_END,    8'h00,  16'd0},
        '{CH_SQUOTE, 1'b0, KIND_END,    8'h00,  16'd0},
        '{CH_BSLASH, 1'b0, KIND_END,    8'h00,  16'd0},
        '{CH_LC_N,   1'b0, KIND_END,    8'h00,  16'd0},
        '{CH_SQUOTE, 1'b0, KIND_END,    8'h00,  16'd0},
        '{CH_DQUOTE, 1'b0, KIND_END,    8'h00,  16'd0},
        '{"A",       1'b0, KIND_END,    8'h00,  16'd0},
        '{CH_DQUOTE, 1'b0, KIND_END,    8'h00,  16'd0},
        '{CH_DOT,    1'b0, KIND_END,    8'h00,  16'd0},
        '{CH_DOT,    1'b0, KIND_END,    8'h00,  16'd0},
        '{CH_NL,     1'b0, KIND_END,    8'h00,  16'd0},  // lone "..": error, '.', newline
        '{CH_NUL,    1'b0, KIND_END,    8'h00,  16'd0}
    };

    c_subset_tokenizer_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_char_in      (i_char_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_record_type  (o_record_type),
        .o_token_kind   (o_token_kind),
        .o_single_char  (o_single_char),
        .o_token_line   (o_token_line),
        .o_token_length (o_token_length),
        .o_literal_byte (o_literal_byte),
        .o_error_code   (o_error_code),
        .o_last         (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- lexer shadow

    function automatic bit is_blank(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit is_dec(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit op_lead(logic [7:0] c);
        return c == CH_LT || c == CH_GT || c == CH_EQ || c == CH_BANG ||
               c == CH_PLUS || c == CH_MINUS || c == CH_AMP || c == CH_BAR;
    endfunction

    // Kind of a two-byte operator, KIND_END when the pair is none.
    function automatic logic [4:0] op_pair_kind(logic [7:0] a, logic [7:0] b);
        case ({a, b})
            {CH_LT, CH_EQ}:       return KIND_LE;
            {CH_GT, CH_EQ}:       return KIND_GE;
            {CH_EQ, CH_EQ}:       return KIND_EQ;
            {CH_BANG, CH_EQ}:     return KIND_NE;
            {CH_PLUS, CH_PLUS}:   return KIND_INC;
            {CH_MINUS, CH_MINUS}: return KIND_DEC;
            {CH_AMP, CH_AMP}:     return KIND_LAND;
            {CH_BAR, CH_BAR}:     return KIND_LOR;
            {CH_MINUS, CH_GT}:    return KIND_ARROW;
            default:              return KIND_END;
        endcase
    endfunction

    // Decode the byte after a backslash; return 0 when it is no escape.
    function automatic bit unescape(logic [7:0] c, output logic [7:0] b);
        b = c;
        case (c)
            CH_ZERO:                       b = CH_NUL;
            CH_LC_N:                       b = CH_NL;
            CH_SQUOTE, CH_DQUOTE, CH_BSLASH: ;
            default:                       return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic void lex_clear();
        lx_mode       = LX_IDLE;
        lx_pending_op = 8'h00;
        lx_line       = 1;
        lx_tok_line   = 1;
        lx_len        = '0;
        lx_halted     = 1'b0;
    endfunction

    function automatic void bump_len();
        if (lx_len != '1) lx_len++;
    endfunction

    function automatic void bump_line();
        if (lx_line != '1) lx_line++;
    endfunction

    function automatic void push_rec(logic [1:0] rtype, logic [4:0] kind, logic [7:0] schar,
                                     logic [LINE_W-1:0] tline, logic [LEN_W-1:0] tlen,
                                     logic [7:0] lit, logic [2:0] err);
        t_tok_rec r;
        r.rtype = rtype;
        r.kind  = kind;
        r.schar = schar;
        r.tline = tline;
        r.tlen  = tlen;
        r.lit   = lit;
        r.err   = err;
        r.last  = 1'b0;
        step_recs.push_back(r);
    endfunction

    function automatic void push_tok(logic [4:0] kind, logic [7:0] schar, logic [LEN_W-1:0] tlen);
        push_rec(REC_TOKEN, kind, schar, lx_tok_line, tlen, 8'h00, ERR_NONE);
    endfunction

    function automatic void push_lit(logic [4:0] kind, logic [7:0] b);
        push_rec(REC_LITERAL, kind, 8'h00, lx_tok_line, '0, b, ERR_NONE);
    endfunction

    function automatic void halt_with(logic [2:0] err, logic [LINE_W-1:0] tline);
        push_rec(REC_ERROR, KIND_END, 8'h00, tline, '0, 8'h00, err);
        lx_mode   = LX_IDLE;
        lx_halted = 1'b1;
    endfunction

    // First byte of a token: single-byte tokens complete at once.
    function automatic void open_token(logic [7:0] c);
        lx_tok_line = lx_line;
        lx_len      = 1;
        lx_mode     = LX_IDLE;
        if (c == CH_NUL) begin
            push_rec(REC_TOKEN, KIND_END, 8'h00, lx_line, '0, 8'h00, ERR_NONE);
            lex_clear();
        end else if (c == CH_NL) begin
            push_tok(KIND_NL, 8'h00, 1);
            bump_line();
        end else if (is_blank(c)) begin
            lx_mode = LX_WS;
        end else if (c == CH_SLASH) begin
            lx_mode = LX_SLASH;
        end else if (is_dec(c)) begin
            lx_mode = LX_NUM;
        end else if (is_letter(c) || c == CH_USCORE) begin
            lx_mode = LX_IDENT;
        end else if (c == CH_SQUOTE) begin
            lx_mode = LX_CHR;
        end else if (c == CH_DQUOTE) begin
            lx_mode = LX_STR;
        end else if (op_lead(c)) begin
            lx_mode       = LX_OP1;
            lx_pending_op = c;
        end else if (c == CH_DOT) begin
            lx_mode = LX_DOT1;
        end else begin
            push_tok(KIND_SINGLE, c, 1);
        end
    endfunction

    // Advance the shadow lexer by one byte; leave its records in step_recs.
    function automatic void lex_byte(logic [7:0] c);
        logic [4:0] k;
        logic [7:0] b;
        step_recs.delete();
        if (lx_halted) return;
        case (lx_mode)
            LX_WS: begin
                if (is_blank(c) && c != CH_NL) bump_len();
                else begin
                    push_tok(KIND_SPACE, 8'h00, lx_len);
                    open_token(c);
                end
            end
            LX_NUM: begin
                if (is_dec(c)) bump_len();
                else begin
                    push_tok(KIND_NUM, 8'h00, lx_len);
                    open_token(c);
                end
            end
            LX_IDENT: begin
                if (is_letter(c) || is_dec(c) || c == CH_USCORE) bump_len();
                else begin
                    push_tok(KIND_IDENT, 8'h00, lx_len);
                    open_token(c);
                end
            end
            LX_SLASH: begin
                if (c == CH_STAR) begin
                    bump_len();
                    lx_mode = LX_COMMENT;
                end else begin
                    push_tok(KIND_SINGLE, CH_SLASH, 1);
                    open_token(c);
                end
            end
            LX_COMMENT, LX_CSTAR: begin
                // A closed comment counts as one space byte.
                if (c == CH_SLASH && lx_mode == LX_CSTAR) begin
                    push_tok(KIND_SPACE, 8'h00, 1);
                    lx_mode = LX_IDLE;
                end else if (c == CH_NUL) begin
                    halt_with(ERR_OPEN_CMT, lx_tok_line);
                end else begin
                    bump_len();
                    if (c == CH_NL) bump_line();
                    lx_mode = (c == CH_STAR) ? LX_CSTAR : LX_COMMENT;
                end
            end
            LX_CHR, LX_STR: begin
                k = (lx_mode == LX_CHR) ? KIND_CHAR : KIND_STR;
                if (k == KIND_STR && c == CH_DQUOTE) begin
                    bump_len();
                    push_tok(KIND_STR, 8'h00, lx_len);
                    lx_mode = LX_IDLE;
                end else if (c == CH_NUL) begin
                    halt_with(ERR_EOF_LIT, lx_line);
                end else if (c == CH_NL) begin
                    halt_with(ERR_NL_LIT, lx_line);
                end else if (c == CH_BSLASH) begin
                    bump_len();
                    lx_mode = (k == KIND_CHAR) ? LX_CHR_ESC : LX_STR_ESC;
                end else begin
                    bump_len();
                    push_lit(k, c);
                    lx_mode = (k == KIND_CHAR) ? LX_CHR_CLOSE : LX_STR;
                end
            end
            LX_CHR_ESC, LX_STR_ESC: begin
                k = (lx_mode == LX_CHR_ESC) ? KIND_CHAR : KIND_STR;
                if (unescape(c, b)) begin
                    bump_len();
                    push_lit(k, b);
                    lx_mode = (k == KIND_CHAR) ? LX_CHR_CLOSE : LX_STR;
                end else begin
                    halt_with(ERR_BAD_ESC, lx_line);
                end
            end
            LX_CHR_CLOSE: begin
                if (c == CH_SQUOTE) begin
                    bump_len();
                    push_tok(KIND_CHAR, 8'h00, lx_len);
                    lx_mode = LX_IDLE;
                end else begin
                    halt_with(ERR_OPEN_CHAR, lx_tok_line);
                end
            end
            LX_OP1: begin
                k = op_pair_kind(lx_pending_op, c);
                if (k != KIND_END) begin
                    push_tok(k, 8'h00, 2);
                    lx_mode = LX_IDLE;
                end else begin
                    push_tok(KIND_SINGLE, lx_pending_op, 1);
                    open_token(c);
                end
            end
            LX_DOT1: begin
                if (c == CH_DOT) begin
                    bump_len();
                    lx_mode = LX_DOT2;
                end else begin
                    push_tok(KIND_SINGLE, CH_DOT, 1);
                    open_token(c);
                end
            end
            LX_DOT2: begin
                // A lone ".." reports, then carries on as a two-byte '.'.
                if (c == CH_DOT) begin
                    push_tok(KIND_VARARGS, 8'h00, 3);
                    lx_mode = LX_IDLE;
                end else begin
                    push_rec(REC_ERROR, KIND_END, 8'h00, lx_tok_line, '0, 8'h00,
                             ERR_DOUBLE_DOT);
                    push_tok(KIND_SINGLE, CH_DOT, 2);
                    open_token(c);
                end
            end
            default: open_token(c);
        endcase
        if (step_recs.size() != 0) step_recs[step_recs.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void report_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    endfunction

    // Sample both channels at the rising edge; inputs only move at the falling edge.
    always @(posedge i_clk) begin : rec_monitor
        t_tok_rec got;
        t_tok_rec want;
        if (i_rst_n) begin
            // Predict on every accepted byte, dropped ones included.
            if (i_in_valid && o_in_ready) begin
                lex_byte(i_char_in);
                if (typed_beat) awaited.push_back(typed_want);
                else foreach (step_recs[j]) awaited.push_back(step_recs[j]);
            end
            if (o_out_valid && i_out_ready) begin
                got.rtype = o_record_type;
                got.kind  = o_token_kind;
                got.schar = o_single_char;
                got.tline = o_token_line;
                got.tlen  = o_token_length;
                got.lit   = o_literal_byte;
                got.err   = o_error_code;
                got.last  = o_last;
                if (awaited.size() == 0) begin
                    $display("%0t: record beat with nothing expected: expected none actual %0h",
                             $time, got);
                    fail_count++;
                end else begin
                    want = awaited.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        report_field("record_type", want.rtype, got.rtype);
                        report_field("token_kind", want.kind, got.kind);
                        report_field("single_char", want.schar, got.schar);
                        report_field("token_line", want.tline, got.tline);
                        report_field("token_length", want.tlen, got.tlen);
                        report_field("literal_byte", want.lit, got.lit);
                        report_field("error_code", want.err, got.err);
                        report_field("last", want.last, got.last);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- pacing

    // Mostly back to back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Sink side: random stalls, plus one long hold-off on request so the queue fills.
    initial begin : sink_pacing
        int stall;
        int r;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (stall != 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
                r = $urandom_range(0, 99);
                if (!calm && r < 20) stall = $urandom_range(1, 3);
                else if (!calm && r < 23) stall = $urandom_range(10, 40);
            end
        end
    end

    // Offer one byte; hold valid and payload until the beat is taken.
    task automatic send_byte(input logic [7:0] c, input bit typed, input t_tok_rec want);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_char_in  <= c;
        typed_beat = typed;
        typed_want = want;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
    endtask

    task automatic send(input logic [7:0] c);
        send_byte(c, 1'b0, '0);
    endtask

    // ---------------------------------------------------------------- token builder

    function automatic logic [7:0] pick_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + (r - 26));
        return CH_USCORE;
    endfunction

    function automatic logic [7:0] pick_escape();
        case ($urandom_range(0, 4))
            0:       return CH_ZERO;
            1:       return CH_SQUOTE;
            2:       return CH_DQUOTE;
            3:       return CH_LC_N;
            default: return CH_BSLASH;
        endcase
    endfunction

    // Plain literal content: anything but NUL, newline, backslash (and '"' in strings).
    function automatic logic [7:0] pick_lit_byte(bit in_string);
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        while (c == CH_NL || c == CH_BSLASH || (in_string && c == CH_DQUOTE))
            c = 8'($urandom_range(1, 255));
        return c;
    endfunction

    // Fill tok_bytes with one well-formed token, or a little noise that opens no
    // literal or comment; a single '/' is always followed by a blank.
    function automatic void build_token();
        int pick;
        int n;
        logic [7:0] c;
        string punct;
        punct = ";,(){}[]*%^~?:#@$";
        tok_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
            tok_bytes.push_back(pick_letter());
            n = $urandom_range(0, 7);
            repeat (n) begin
                c = ($urandom_range(0, 3) == 0) ? 8'("0" + $urandom_range(0, 9))
                                                : pick_letter();
                tok_bytes.push_back(c);
            end
        end else if (pick < 24) begin
            n = $urandom_range(1, 6);
            repeat (n) tok_bytes.push_back(8'("0" + $urandom_range(0, 9)));
        end else if (pick < 34) begin
            n = $urandom_range(1, 4);
            repeat (n) begin
                case ($urandom_range(0, 4))
                    0:       c = 8'h20;
                    1:       c = 8'h09;
                    2:       c = 8'h0B;
                    3:       c = 8'h0C;
                    default: c = 8'h0D;
                endcase
                tok_bytes.push_back(c);
            end
        end else if (pick < 40) begin
            tok_bytes.push_back(CH_NL);
        end else if (pick < 47) begin
            tok_bytes.push_back(CH_SLASH);
            tok_bytes.push_back(CH_STAR);
            n = $urandom_range(0, 6);
            repeat (n) begin
                c = 8'($urandom_range(1, 255));
                if (c == CH_SLASH) c = CH_STAR;
                tok_bytes.push_back(c);
            end
            tok_bytes.push_back(CH_STAR);
            tok_bytes.push_back(CH_SLASH);
        end else if (pick < 54) begin
            tok_bytes.push_back(CH_SQUOTE);
            if ($urandom_range(0, 2) == 0) begin
                tok_bytes.push_back(CH_BSLASH);
                tok_bytes.push_back(pick_escape());
            end else begin
                tok_bytes.push_back(pick_lit_byte(1'b0));
            end
            tok_bytes.push_back(CH_SQUOTE);
        end else if (pick < 62) begin
            tok_bytes.push_back(CH_DQUOTE);
            n = $urandom_range(0, 5);
            repeat (n) begin
                if ($urandom_range(0, 3) == 0) begin
                    tok_bytes.push_back(CH_BSLASH);
                    tok_bytes.push_back(pick_escape());
                end else begin
                    tok_bytes.push_back(pick_lit_byte(1'b1));
                end
            end
            tok_bytes.push_back(CH_DQUOTE);
        end else if (pick < 71) begin
            case ($urandom_range(0, 8))
                0:       begin tok_bytes.push_back(CH_LT);    tok_bytes.push_back(CH_EQ);    end
                1:       begin tok_bytes.push_back(CH_GT);    tok_bytes.push_back(CH_EQ);    end
                2:       begin tok_bytes.push_back(CH_EQ);    tok_bytes.push_back(CH_EQ);    end
                3:       begin tok_bytes.push_back(CH_BANG);  tok_bytes.push_back(CH_EQ);    end
                4:       begin tok_bytes.push_back(CH_PLUS);  tok_bytes.push_back(CH_PLUS);  end
                5:       begin tok_bytes.push_back(CH_MINUS); tok_bytes.push_back(CH_MINUS); end
                6:       begin tok_bytes.push_back(CH_AMP);   tok_bytes.push_back(CH_AMP);   end
                7:       begin tok_bytes.push_back(CH_BAR);   tok_bytes.push_back(CH_BAR);   end
                default: begin tok_bytes.push_back(CH_MINUS); tok_bytes.push_back(CH_GT);    end
            endcase
        end else if (pick < 76) begin
            case ($urandom_range(0, 7))
                0:       c = CH_LT;
                1:       c = CH_GT;
                2:       c = CH_EQ;
                3:       c = CH_BANG;
                4:       c = CH_PLUS;
                5:       c = CH_MINUS;
                6:       c = CH_AMP;
                default: c = CH_BAR;
            endcase
            tok_bytes.push_back(c);
        end else if (pick < 81) begin
            // One, two (lone "..") or three dots.
            n = $urandom_range(1, 3);
            repeat (n) tok_bytes.push_back(CH_DOT);
        end else if (pick < 89) begin
            case ($urandom_range(0, 3))
                0, 1: tok_bytes.push_back(8'($urandom_range(128, 255)));
                2:    tok_bytes.push_back(punct[$urandom_range(0, punct.len() - 1)]);
                default: begin
                    tok_bytes.push_back(CH_SLASH);
                    tok_bytes.push_back(8'h20);
                end
            endcase
        end else if (pick < 92) begin
            tok_bytes.push_back(CH_NUL);
        end else begin
            n = $urandom_range(1, 3);
            repeat (n) begin
                c = 8'($urandom_range(0, 255));
                while (c == CH_SQUOTE || c == CH_DQUOTE || c == CH_SLASH)
                    c = 8'($urandom_range(0, 255));
                tok_bytes.push_back(c);
            end
        end
    endfunction

    // ---------------------------------------------------------------- stimulus

    initial begin : stimulus
        t_tok_rec want;
        int sent;
        int guard;
        bit held;
        bit paused;
        lex_clear();
        held   = 1'b0;
        paused = 1'b0;

        // Hold reset, then release it on a falling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table; typed rows are single token records on line 1.
        foreach (script[i]) begin
            want.rtype = REC_TOKEN;
            want.kind  = script[i].kind;
            want.schar = script[i].schar;
            want.tline = 1;
            want.tlen  = script[i].tlen;
            want.lit   = 8'h00;
            want.err   = ERR_NONE;
            want.last  = 1'b1;
            send_byte(script[i].ch, script[i].typed, want);
        end

        // Random token stream. Midway: one long sink hold-off while bytes keep
        // coming, one pause of the source until every record is in, then a calm stretch.
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            build_token();
            foreach (tok_bytes[i]) send(tok_bytes[i]);
            sent += tok_bytes.size();
            if (!held && sent >= 60) begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            if (!paused && sent >= 120) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                while (awaited.size() != 0) @(posedge i_clk);
                paused = 1'b1;
            end
            calm = (sent >= 130 && sent < 160);
        end

        // Finish with one halting error, chosen at random, then bytes that get dropped.
        case ($urandom_range(1, 5))
            ERR_EOF_LIT: begin
                send(CH_DQUOTE); send("a"); send(CH_NUL);
            end
            ERR_NL_LIT: begin
                send(CH_SQUOTE); send(CH_NL);
            end
            ERR_BAD_ESC: begin
                send(CH_DQUOTE); send(CH_BSLASH); send("q");
            end
            ERR_OPEN_CMT: begin
                send(CH_SLASH); send(CH_STAR); send("x"); send(CH_NL); send(CH_NUL);
            end
            default: begin
                send(CH_SQUOTE); send("a"); send("b");
            end
        endcase
        repeat (4) send(8'($urandom_range(0, 255)));
        send(CH_NUL);

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Drain, then keep watching so that anything unexpected can show up.
        guard = 0;
        while (awaited.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
        if (awaited.size() != 0) begin
            $display("%0t: %0d record beats never arrived, next expected %0h",
                     $time, awaited.size(), awaited[0]);
            fail_count++;
        end

        if (fail_count == 0)
            $display("[c_subset_tokenizer_core] OK");
        else
            $display("[c_subset_tokenizer_core] ERROR");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin : watchdog
        #4_000_000;
        $display("[c_subset_tokenizer_core] ERROR");
        $finish;
    end

endmodule
